FILE: hw/rtl/ille_pkg.sv
// ----------------------------------------------------------------------------
// ille_pkg
// Shared types and codes of the indexed linked list engine: operation and
// status codes, sequencer states and the control groups of the link walker.
// ----------------------------------------------------------------------------
package ille_pkg;

  // Operation codes carried by each input item
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_REMOVE_AT  = 3'd5,
    OP_READ       = 3'd6,
    OP_CLEAR      = 3'd7
  } ille_op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } ille_status_e;

  // Kind of list work in flight
  typedef enum logic [1:0] {
    KIND_INS,
    KIND_RM,
    KIND_RD
  } ille_kind_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_INS_LINK,
    S_INS_FIX,
    S_RM_HEAD,
    S_RM_LINK,
    S_RM_SKIP,
    S_RM_FREE,
    S_RD_OUT
  } ille_state_e;

  // Requests from the sequencer to the link walker
  typedef struct packed {
    logic walk_start;
    logic rd_en;
    logic wr_en;
  } ille_walk_ctl_t;

  // Status from the link walker
  typedef struct packed {
    logic busy;
    logic done;
  } ille_walk_sts_t;

endpackage

FILE: hw/rtl/ille_walk.sv
// ----------------------------------------------------------------------------
// ille_walk
// Link store with a pointer walker. Holds the next-slot link of every node
// in a synchronous memory and follows links from a start slot, one link per
// cycle, by feeding the registered read data back as the next address.
// ----------------------------------------------------------------------------
module ille_walk #(
  parameter int unsigned Depth = 64,
  parameter int unsigned SlotW = 6,
  parameter int unsigned StepW = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ille_pkg::ille_walk_ctl_t ctl_i,
  input  logic [SlotW-1:0]        from_i,
  input  logic [StepW-1:0]        steps_i,
  input  logic [SlotW-1:0]        rd_addr_i,
  input  logic [SlotW-1:0]        wr_addr_i,
  input  logic [SlotW-1:0]        wr_data_i,
  output ille_pkg::ille_walk_sts_t sts_o,
  output logic [SlotW-1:0]        slot_o,
  output logic [SlotW-1:0]        rd_data_o
);
  import ille_pkg::*;

  logic [SlotW-1:0] link_mem [Depth];
  logic [SlotW-1:0] rd_data_q;
  logic [SlotW-1:0] cur_q, cur_d, cur;
  logic [StepW-1:0] remain_q, remain_d;
  logic             active_q, active_d;
  logic             pend_q, pend_d;
  logic             rd_en;
  logic [SlotW-1:0] rd_addr;
  logic             done;

  // Current slot: forward the link just read while a step is pending
  assign cur = pend_q ? rd_data_q : cur_q;

  // Walk control and read port arbitration
  always_comb begin
    active_d = active_q;
    remain_d = remain_q;
    pend_d   = 1'b0;
    cur_d    = cur_q;
    rd_en    = ctl_i.rd_en;
    rd_addr  = rd_addr_i;
    done     = 1'b0;
    if (active_q) begin
      rd_en   = 1'b1;
      rd_addr = cur;
      cur_d   = cur;
      if (remain_q == '0) begin
        // Arrived: also fetch the link of the slot reached
        done     = 1'b1;
        active_d = 1'b0;
      end else begin
        remain_d = remain_q - 1'b1;
        pend_d   = 1'b1;
      end
    end
    if (ctl_i.walk_start) begin
      active_d = 1'b1;
      cur_d    = from_i;
      remain_d = steps_i;
      pend_d   = 1'b0;
    end
  end

  // Hold walker control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      pend_q   <= pend_d;
    end
  end

  // Walker payload
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    remain_q <= remain_d;
  end

  // Link memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      link_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_data_q <= link_mem[rd_addr];
    end
  end

  assign sts_o.busy = active_q;
  assign sts_o.done = done;
  assign slot_o     = cur;
  assign rd_data_o  = rd_data_q;

endmodule

FILE: hw/rtl/indexed_linked_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// Ordered list of signed values kept as linked nodes in two memories, with
// head pointer, element count and a free-slot allocator.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// on the result ports for a single cycle with done_o high, in the cycle after
// the item's last cycle, and the receiver cannot hold it off. Failed
// operations, clear, and a push front or insert at position 0 into a
// never-used slot finish in the cycle they are taken (busy stays low). Push
// front into a freed slot passes S_ALLOC; pop front and remove at position 0
// pass S_RM_HEAD. A positional operation follows links from the head one
// node per cycle through the single read port of the link memory: a read
// at position p walks p links, then S_RD_OUT; insert at p>0 (S_ALLOC first
// when a freed slot is reused) walks to its predecessor, then S_INS_LINK and
// S_INS_FIX; remove at p>0 walks to its predecessor, then S_RM_LINK,
// S_RM_SKIP and S_RM_FREE; pop back is a remove at the last position. The
// result strobe comes in the first cycle with busy low again, where the next
// item may already be taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module indexed_linked_list_engine #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] value_i,
  input  logic [6:0]         position_i,
  output logic               done_o,
  output logic signed [31:0] read_value_o,
  output logic [6:0]         count_o,
  output logic [1:0]         status_o
);
  import ille_pkg::*;

  localparam int unsigned SW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  // List state
  ille_state_e            state_q, state_d;
  logic [SW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [SW-1:0]          free_q, free_d;
  logic [CW-1:0]          fresh_q, fresh_d;

  // Item in flight
  ille_kind_e             kind_q, kind_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic [SW-1:0]          slot_q, slot_d;
  logic [SW-1:0]          prev_q, prev_d;
  logic [SW-1:0]          gone_q, gone_d;

  // Result
  logic                   res_valid_q, res_valid_d;
  logic [31:0]            res_value_q, res_value_d;
  logic [6:0]             res_count_q, res_count_d;
  ille_status_e           res_status_q, res_status_d;

  // Link walker interface
  ille_walk_ctl_t         wctl;
  ille_walk_sts_t         wsts;
  logic [SW-1:0]          w_from, w_rd_addr, w_wr_addr, w_wr_data, w_slot, link_rd;
  logic [CW-1:0]          w_steps;

  // Value memory
  logic [VALUE_BITS-1:0]  val_mem [CAPACITY];
  logic [VALUE_BITS-1:0]  val_rd_q;
  logic                   vm_we, vm_re;
  logic [SW-1:0]          vm_waddr, vm_raddr;
  logic [VALUE_BITS-1:0]  vm_wdata;

  // Decode helpers
  ille_op_e               op;
  logic [63:0]            value_ext;
  logic [VALUE_BITS-1:0]  value_st;
  logic [CMPW-1:0]        pos_ext, cnt_ext, cnt_out_ext;
  logic [63:0]            rd_ext;
  logic                   full, empty, reuse;
  logic                   fin;
  ille_status_e           fin_status;
  logic [31:0]            fin_value;
  logic                   do_place;
  logic [SW-1:0]          pl_slot;
  logic [CW-1:0]          pl_tgt;

  assign op        = ille_op_e'(operation_i);
  assign value_ext = {{32{value_i[31]}}, value_i};
  assign value_st  = value_ext[VALUE_BITS-1:0];
  assign pos_ext   = CMPW'(position_i);
  assign cnt_ext   = CMPW'(count_q);
  assign full      = (count_q == CapCnt);
  assign empty     = (count_q == '0);
  assign reuse     = (fresh_q > count_q);
  assign rd_ext    = 64'(val_rd_q);

  // Sequencer: next state, list updates and memory requests
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    free_d     = free_q;
    fresh_d    = fresh_q;
    kind_d     = kind_q;
    pos_d      = pos_q;
    val_d      = val_q;
    slot_d     = slot_q;
    prev_d     = prev_q;
    gone_d     = gone_q;
    wctl       = '0;
    w_from     = head_q;
    w_steps    = '0;
    w_rd_addr  = '0;
    w_wr_addr  = '0;
    w_wr_data  = '0;
    vm_we      = 1'b0;
    vm_re      = 1'b0;
    vm_waddr   = '0;
    vm_raddr   = w_slot;
    vm_wdata   = val_q;
    fin        = 1'b0;
    fin_status = STAT_OK;
    fin_value  = '0;
    do_place   = 1'b0;
    pl_slot    = slot_q;
    pl_tgt     = pos_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          val_d = value_st;
          case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
              kind_d = KIND_INS;
              if (op == OP_PUSH_FRONT) begin
                pos_d = '0;
              end else if (op == OP_PUSH_BACK) begin
                pos_d = count_q;
              end else begin
                pos_d = pos_ext[CW-1:0];
              end
              if (full) begin
                fin        = 1'b1;
                fin_status = STAT_FULL;
              end else if (op == OP_INSERT && pos_ext > cnt_ext) begin
                fin        = 1'b1;
                fin_status = STAT_RANGE;
              end else if (reuse) begin
                // Take the head of the free chain; its link is the new chain head
                wctl.rd_en = 1'b1;
                w_rd_addr  = free_q;
                slot_d     = free_q;
                state_d    = S_ALLOC;
              end else begin
                // Take a never-used slot
                fresh_d  = fresh_q + 1'b1;
                vm_we    = 1'b1;
                vm_waddr = fresh_q[SW-1:0];
                vm_wdata = value_st;
                slot_d   = fresh_q[SW-1:0];
                do_place = 1'b1;
                pl_slot  = fresh_q[SW-1:0];
                pl_tgt   = pos_d;
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
              kind_d = KIND_RM;
              if (op == OP_POP_FRONT) begin
                pos_d = '0;
              end else if (op == OP_POP_BACK) begin
                pos_d = count_q - 1'b1;
              end else begin
                pos_d = pos_ext[CW-1:0];
              end
              if (op != OP_REMOVE_AT && empty) begin
                fin        = 1'b1;
                fin_status = STAT_EMPTY;
              end else if (op == OP_REMOVE_AT && pos_ext >= cnt_ext) begin
                fin        = 1'b1;
                fin_status = STAT_RANGE;
              end else if (pos_d == '0) begin
                // Unlink the head: fetch its successor
                wctl.rd_en = 1'b1;
                w_rd_addr  = head_q;
                gone_d     = head_q;
                state_d    = S_RM_HEAD;
              end else begin
                wctl.walk_start = 1'b1;
                w_steps         = pos_d - 1'b1;
                state_d         = S_WALK;
              end
            end
            OP_READ: begin
              kind_d = KIND_RD;
              pos_d  = pos_ext[CW-1:0];
              if (pos_ext >= cnt_ext) begin
                fin        = 1'b1;
                fin_status = STAT_RANGE;
              end else begin
                wctl.walk_start = 1'b1;
                w_steps         = pos_d;
                state_d         = S_WALK;
              end
            end
            default: begin
              // Clear list, free chain and allocator at once
              head_d  = '0;
              count_d = '0;
              free_d  = '0;
              fresh_d = '0;
              fin     = 1'b1;
            end
          endcase
        end
      end

      S_ALLOC: begin
        free_d   = link_rd;
        vm_we    = 1'b1;
        vm_waddr = slot_q;
        do_place = 1'b1;
      end

      S_WALK: begin
        if (wsts.done) begin
          prev_d = w_slot;
          case (kind_q)
            KIND_INS: state_d = S_INS_LINK;
            KIND_RM:  state_d = S_RM_LINK;
            default: begin
              vm_re   = 1'b1;
              state_d = S_RD_OUT;
            end
          endcase
        end
      end

      S_INS_LINK: begin
        // New node takes over the successor of its predecessor
        wctl.wr_en = 1'b1;
        w_wr_addr  = slot_q;
        w_wr_data  = link_rd;
        state_d    = S_INS_FIX;
      end

      S_INS_FIX: begin
        wctl.wr_en = 1'b1;
        w_wr_addr  = prev_q;
        w_wr_data  = slot_q;
        count_d    = count_q + 1'b1;
        fin        = 1'b1;
      end

      S_RM_HEAD: begin
        head_d     = link_rd;
        wctl.wr_en = 1'b1;
        w_wr_addr  = gone_q;
        w_wr_data  = free_q;
        free_d     = gone_q;
        count_d    = count_q - 1'b1;
        fin        = 1'b1;
      end

      S_RM_LINK: begin
        // Latch the node to drop and fetch its successor
        gone_d     = link_rd;
        wctl.rd_en = 1'b1;
        w_rd_addr  = link_rd;
        state_d    = S_RM_SKIP;
      end

      S_RM_SKIP: begin
        wctl.wr_en = 1'b1;
        w_wr_addr  = prev_q;
        w_wr_data  = link_rd;
        state_d    = S_RM_FREE;
      end

      S_RM_FREE: begin
        // Return the dropped slot to the free chain
        wctl.wr_en = 1'b1;
        w_wr_addr  = gone_q;
        w_wr_data  = free_q;
        free_d     = gone_q;
        count_d    = count_q - 1'b1;
        fin        = 1'b1;
      end

      S_RD_OUT: begin
        fin_value = rd_ext[31:0];
        fin       = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Place a freshly allocated node at its target position
    if (do_place) begin
      if (pl_tgt == '0) begin
        wctl.wr_en = 1'b1;
        w_wr_addr  = pl_slot;
        w_wr_data  = head_q;
        head_d     = pl_slot;
        count_d    = count_q + 1'b1;
        fin        = 1'b1;
      end else begin
        wctl.walk_start = 1'b1;
        w_steps         = pl_tgt - 1'b1;
        state_d         = S_WALK;
      end
    end

    if (fin) begin
      state_d = S_IDLE;
    end
  end

  // Result fields
  assign cnt_out_ext  = CMPW'(count_d);
  assign res_valid_d  = fin;
  assign res_value_d  = fin ? fin_value : res_value_q;
  assign res_count_d  = fin ? cnt_out_ext[6:0] : res_count_q;
  assign res_status_d = fin ? fin_status : res_status_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      free_q      <= '0;
      fresh_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      free_q      <= free_d;
      fresh_q     <= fresh_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    slot_q       <= slot_d;
    prev_q       <= prev_d;
    gone_q       <= gone_d;
    res_value_q  <= res_value_d;
    res_count_q  <= res_count_d;
    res_status_q <= res_status_d;
  end

  // Value memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      val_mem[vm_waddr] <= vm_wdata;
    end
    if (vm_re) begin
      val_rd_q <= val_mem[vm_raddr];
    end
  end

  // Link store and walker
  ille_walk #(
    .Depth (CAPACITY),
    .SlotW (SW),
    .StepW (CW)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (wctl),
    .from_i    (w_from),
    .steps_i   (w_steps),
    .rd_addr_i (w_rd_addr),
    .wr_addr_i (w_wr_addr),
    .wr_data_i (w_wr_data),
    .sts_o     (wsts),
    .slot_o    (w_slot),
    .rd_data_o (link_rd)
  );

  assign busy         = (state_q != S_IDLE);
  assign done_o       = res_valid_q;
  assign read_value_o = res_value_q;
  assign count_o      = res_count_q;
  assign status_o     = res_status_q;

endmodule

FILE: tb/sv/ille_checker.sv
// ----------------------------------------------------------------------------
// ille_checker
// Watches the command and result channels of the indexed linked list engine,
// keeps its own ordered list of values, predicts the answer of every item it
// sees accepted and compares each result strobe against the oldest answer.
// ----------------------------------------------------------------------------
module ille_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] value_i,
  input  logic [6:0]         position_i,
  input  logic               done_i,
  input  logic signed [31:0] read_value_i,
  input  logic [6:0]         count_i,
  input  logic [1:0]         status_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 full_hits_o,
  output int                 empty_hits_o,
  output int                 range_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ille_pkg::*;

  localparam int unsigned LIST_CAPACITY = 64;
  localparam int          MAX_REPORTS   = 10;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [6:0]         count;
    ille_status_e       status;
  } list_answer_t;

  // Element values in list order, front first
  logic signed [31:0] list_vals[$];
  // Answers of accepted items still waiting for their result strobe
  list_answer_t       answer_q[$];

  int fails      = 0;
  int results    = 0;
  int full_hits  = 0;
  int empty_hits = 0;
  int range_hits = 0;

  // Apply one operation to the list and return what the block must answer
  function automatic list_answer_t apply_list_op(ille_op_e op, logic signed [31:0] val,
                                                 logic [6:0] pos);
    list_answer_t ans;
    int unsigned  len;
    ans.read_value = '0;
    ans.status     = STAT_OK;
    len            = list_vals.size();
    case (op)
      OP_PUSH_FRONT: begin
        if (len >= LIST_CAPACITY) ans.status = STAT_FULL;
        else list_vals.insert(0, val);
      end
      OP_PUSH_BACK: begin
        if (len >= LIST_CAPACITY) ans.status = STAT_FULL;
        else list_vals.insert(len, val);
      end
      OP_POP_FRONT: begin
        if (len == 0) ans.status = STAT_EMPTY;
        else list_vals.delete(0);
      end
      OP_POP_BACK: begin
        if (len == 0) ans.status = STAT_EMPTY;
        else list_vals.delete(len - 1);
      end
      OP_INSERT: begin
        // full takes precedence over a bad position
        if (len >= LIST_CAPACITY) ans.status = STAT_FULL;
        else if (pos > len) ans.status = STAT_RANGE;
        else list_vals.insert(pos, val);
      end
      OP_REMOVE_AT: begin
        if (pos >= len) ans.status = STAT_RANGE;
        else list_vals.delete(pos);
      end
      OP_READ: begin
        if (pos >= len) ans.status = STAT_RANGE;
        else ans.read_value = list_vals[pos];
      end
      default: begin
        list_vals.delete();
      end
    endcase
    ans.count = 7'(list_vals.size());
    return ans;
  endfunction

  // Compare results first, then log newly accepted items
  always @(posedge clk_i) begin
    list_answer_t want;
    if (rst_ni) begin
      if (done_i) begin
        results++;
        case (status_i)
          STAT_FULL:  full_hits++;
          STAT_EMPTY: empty_hits++;
          STAT_RANGE: range_hits++;
          default: ;
        endcase
        if (answer_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("[%0t] result with no item pending: value %0d count %0d status %0d",
                     $time, read_value_i, count_i, status_i);
        end else begin
          want = answer_q[0];
          answer_q.delete(0);
          if (read_value_i !== want.read_value || count_i !== want.count ||
              status_i !== want.status) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("[%0t] expected value %0d count %0d status %s, got %0d %0d %0d",
                       $time, want.read_value, want.count, want.status.name(),
                       read_value_i, count_i, status_i);
          end
        end
      end
      if (start_i && !busy_i)
        answer_q.insert(answer_q.size(),
                        apply_list_op(ille_op_e'(operation_i), value_i, position_i));
    end
    // publish with nonblocking updates so readers at this edge see stable values
    fail_count_o <= fails;
    pending_o    <= answer_q.size();
    results_o    <= results;
    full_hits_o  <= full_hits;
    empty_hits_o <= empty_hits;
    range_hits_o <= range_hits;
  end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the indexed linked list engine with a directed opening and then
// random operation mixes that grow, drain and churn the list, with random
// gaps between items in some phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ille_pkg::*;

  localparam int unsigned LIST_CAPACITY = 64;
  localparam int          RANDOM_ITEMS  = 1000;
  localparam int          PHASE_ITEMS   = 50;
  localparam int          DRAIN_CYCLES  = 80;
  localparam int          CYCLE_LIMIT   = 500000;

  // Phase flavors of the random part
  localparam int MODE_GROW  = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED = 2;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [2:0]         operation;
  logic signed [31:0] value;
  logic [6:0]         position;
  logic               done;
  logic signed [31:0] read_value;
  logic [6:0]         count;
  logic [1:0]         status;

  int fails;
  int pending;
  int results;
  int full_hits;
  int empty_hits;
  int range_hits;

  int          cycle_count = 0;
  int          items_sent  = 0;
  int unsigned list_len    = 0;
  bit          no_gaps     = 1'b0;

  indexed_linked_list_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation),
    .value_i      (value),
    .position_i   (position),
    .done_o       (done),
    .read_value_o (read_value),
    .count_o      (count),
    .status_o     (status)
  );

  ille_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .operation_i  (operation),
    .value_i      (value),
    .position_i   (position),
    .done_i       (done),
    .read_value_i (read_value),
    .count_i      (count),
    .status_i     (status),
    .fail_count_o (fails),
    .pending_o    (pending),
    .results_o    (results),
    .full_hits_o  (full_hits),
    .empty_hits_o (empty_hits),
    .range_hits_o (range_hits)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("indexed_linked_list_engine test failed");
      $finish;
    end
  end

  // Present one item after a random gap and hold it until taken
  task automatic send_item(ille_op_e op, logic signed [31:0] val, logic [6:0] pos);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    operation <= op;
    value     <= val;
    position  <= pos;
    do @(posedge clk_i); while (busy);
    items_sent++;
    // track the size to keep positions mostly meaningful
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (list_len < LIST_CAPACITY) list_len++;
      OP_INSERT:    if (list_len < LIST_CAPACITY && pos <= list_len) list_len++;
      OP_POP_FRONT, OP_POP_BACK: if (list_len > 0) list_len--;
      OP_REMOVE_AT: if (pos < list_len) list_len--;
      OP_CLEAR:     list_len = 0;
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'sh7FFF_FFFF;
    if (r < 20) return 32'sh8000_0000;
    if (r < 35) return 32'($urandom_range(0, 15)) - 32'sd8;
    return $urandom;
  endfunction

  // Draw one operation weighted by the phase flavor
  task automatic send_random(int mode);
    int         r;
    logic [6:0] in_pos;
    logic [6:0] ins_pos;
    r       = $urandom_range(0, 99);
    in_pos  = (list_len == 0) ? 7'd0 : 7'($urandom_range(0, list_len - 1));
    ins_pos = 7'($urandom_range(0, list_len));
    if (r < 2) begin
      send_item(OP_CLEAR, $urandom, 7'($urandom));
    end else if (r < 12) begin
      // noise: any operation but clear, any position
      send_item(ille_op_e'($urandom_range(0, 6)), pick_value(), 7'($urandom_range(0, 127)));
    end else begin
      r = $urandom_range(0, 99);
      case (mode)
        MODE_GROW: begin
          if (r < 25)      send_item(OP_PUSH_FRONT, pick_value(), 7'($urandom));
          else if (r < 50) send_item(OP_PUSH_BACK, pick_value(), 7'($urandom));
          else if (r < 80) send_item(OP_INSERT, pick_value(), ins_pos);
          else if (r < 92) send_item(OP_READ, $urandom, in_pos);
          else             send_item(OP_REMOVE_AT, $urandom, in_pos);
        end
        MODE_SHRINK: begin
          if (r < 20)      send_item(OP_POP_FRONT, $urandom, 7'($urandom));
          else if (r < 40) send_item(OP_POP_BACK, $urandom, 7'($urandom));
          else if (r < 70) send_item(OP_REMOVE_AT, $urandom, in_pos);
          else if (r < 85) send_item(OP_READ, $urandom, in_pos);
          else             send_item(OP_INSERT, pick_value(), ins_pos);
        end
        default: begin
          if (r < 12)      send_item(OP_PUSH_FRONT, pick_value(), 7'($urandom));
          else if (r < 24) send_item(OP_PUSH_BACK, pick_value(), 7'($urandom));
          else if (r < 40) send_item(OP_INSERT, pick_value(), ins_pos);
          else if (r < 50) send_item(OP_POP_FRONT, $urandom, 7'($urandom));
          else if (r < 60) send_item(OP_POP_BACK, $urandom, 7'($urandom));
          else if (r < 75) send_item(OP_REMOVE_AT, $urandom, in_pos);
          else             send_item(OP_READ, $urandom, in_pos);
        end
      endcase
    end
  endtask

  initial begin
    int mode;
    rst_ni    = 1'b0;
    start     = 1'b0;
    operation = OP_READ;
    value     = '0;
    position  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list errors, extremes, every operation, clear
    send_item(OP_READ,       32'sd0,           7'd0);
    send_item(OP_POP_FRONT,  32'sd0,           7'd0);
    send_item(OP_POP_BACK,   32'sd0,           7'd0);
    send_item(OP_REMOVE_AT,  32'sd0,           7'd0);
    send_item(OP_INSERT,     32'sd5,           7'd1);
    send_item(OP_PUSH_FRONT, 32'sh7FFF_FFFF,   7'd0);
    send_item(OP_PUSH_BACK,  32'sh8000_0000,   7'd127);
    send_item(OP_INSERT,     -32'sd1,          7'd1);
    send_item(OP_INSERT,     32'sd0,           7'd0);
    send_item(OP_INSERT,     32'sh5555_5555,   7'd4);
    send_item(OP_INSERT,     32'shAAAA_AAAA,   7'd127);
    for (int p = 0; p <= 4; p++) send_item(OP_READ, 32'sd0, 7'(p));
    send_item(OP_READ,       32'sd0,           7'd64);
    send_item(OP_REMOVE_AT,  32'sd0,           7'd2);
    send_item(OP_REMOVE_AT,  32'sd0,           7'd3);
    send_item(OP_POP_BACK,   32'sd0,           7'd0);
    send_item(OP_POP_FRONT,  32'sd0,           7'd0);
    send_item(OP_CLEAR,      -32'sd1,          7'd127);
    send_item(OP_READ,       32'sd0,           7'd0);
    send_item(OP_PUSH_BACK,  32'sd1,           7'd0);
    send_item(OP_POP_FRONT,  32'sd0,           7'd0);

    // Random: phases that fill, drain or churn the list
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        mode    = $urandom_range(MODE_GROW, MODE_MIXED);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      send_random(mode);
    end

    // Drain: wait out every pending answer, then the longest walk
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results in %0d cycles",
             items_sent, results, cycle_count);
    $display("Error answers seen: full %0d, empty %0d, out of range %0d",
             full_hits, empty_hits, range_hits);
    if (fails == 0 && pending == 0) begin
      $display("indexed_linked_list_engine test passed");
    end else begin
      $display("indexed_linked_list_engine test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ille_pkg.sv
hw/rtl/ille_walk.sv
hw/rtl/indexed_linked_list_engine.sv
tb/sv/ille_checker.sv
tb/sv/tb_top.sv
